FILE: hdl/qte_pkg.sv
// Shared types, constants and helper functions of the quaternion to Euler angle core.
// Depends on nothing; used by every module in hdl/.
package qte_pkg;

  localparam int QW        = 16;   // working component width, Q1.14
  localparam int PW        = 32;   // product width
  localparam int NUMW      = 34;   // signed matrix numerator
  localparam int NORMW     = 33;   // squared norm
  localparam int MFRAC     = 30;   // matrix entries are Q1.30
  localparam int EW        = 32;   // signed matrix entry
  localparam int DIVQ      = 31;   // quotient bits of the scaling divider
  localparam int REMW      = 63;   // divider remainder
  localparam int DIV_LAT   = DIVQ + 2;
  localparam int SQW       = 64;   // radicand width
  localparam int SQ_STEPS  = 32;
  localparam int SQRT_LAT  = SQ_STEPS + 1;
  localparam int MAGW      = 32;
  localparam int OPW       = 33;   // atan2 operand
  localparam int CW        = 36;   // CORDIC x/y datapath
  localparam int ZW        = 32;   // CORDIC angle accumulator, Q3.28
  localparam int AW        = 15;   // output angle, Q2.12
  localparam int SLOTS     = 7;    // matrix entries needed per order
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_AW    = 3;
  localparam int AXIS_W    = 5;
  localparam int THR_W     = 8;
  localparam int CFG_DW    = 32;

  localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [AW-1:0] PI_Q12      = 15'sd12868;

  localparam logic REG_AXIS_ORDER = 1'b0;
  localparam logic REG_SING_THR   = 1'b1;

  typedef logic [1:0] axis_t;

  typedef struct packed {
    logic  frame;
    logic  rep;
    logic  par;
    axis_t i;
    axis_t j;
    axis_t k;
  } order_t;

  function automatic axis_t next_axis(axis_t a);
    axis_t r;
    case (a)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      2'd2:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic order_t decode_order(logic [AXIS_W-1:0] ao);
    order_t o;
    o.frame = ao[0];
    o.rep   = ao[1];
    o.par   = ao[2];
    o.i     = (ao[4:3] == 2'd3) ? 2'd0 : ao[4:3];
    o.j     = next_axis(2'(o.i + {1'b0, o.par}));
    o.k     = next_axis(2'(o.i + 2'd1 - {1'b0, o.par}));
    return o;
  endfunction

  // atan(2^-i) in Q3.28
  function automatic logic signed [ZW-1:0] atan_q28(int unsigned idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0:       r = 32'sd210828714;
      1:       r = 32'sd124459457;
      2:       r = 32'sd65760959;
      3:       r = 32'sd33381290;
      4:       r = 32'sd16755422;
      5:       r = 32'sd8385879;
      6:       r = 32'sd4193963;
      7:       r = 32'sd2097109;
      8:       r = 32'sd1048571;
      9:       r = 32'sd524287;
      10:      r = 32'sd262144;
      11:      r = 32'sd131072;
      12:      r = 32'sd65536;
      13:      r = 32'sd32768;
      14:      r = 32'sd16384;
      15:      r = 32'sd8192;
      16:      r = 32'sd4096;
      17:      r = 32'sd2048;
      18:      r = 32'sd1024;
      19:      r = 32'sd512;
      20:      r = 32'sd256;
      21:      r = 32'sd128;
      22:      r = 32'sd64;
      23:      r = 32'sd32;
      24:      r = 32'sd16;
      25:      r = 32'sd8;
      26:      r = 32'sd4;
      27:      r = 32'sd2;
      28:      r = 32'sd1;
      29:      r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/quaternion_to_euler_angles_core.sv
// Quaternion to Euler angles, 24 axis orders. The pipeline runs through the 31-stage entry divider,
// the 32-stage square root and the CORDIC stages.
// Throughput one quaternion per cycle; the whole pipeline holds while a result waits unread.
// Reset (synchronous, rst_n low) clears all valid bits and sets axis_order 0, threshold 1.
// Depends on qte_pkg, qte_div, qte_isqrt, qte_cordic.
module quaternion_to_euler_angles_core #(
  parameter int DATA_WIDTH   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: quat_x, quat_y, quat_z, quat_w (DATA_WIDTH each, lowest first), zero padded
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]  in_tdata,
  // out_tdata: angle_first [14:0], angle_second [29:15], angle_third [44:30], zero padded
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [qte_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [qte_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [qte_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [qte_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);

  localparam int PRE      = (DATA_WIDTH > qte_pkg::QW) ? DATA_WIDTH - qte_pkg::QW : 0;
  localparam int E_DLY    = 1 + qte_pkg::SQRT_LAT;
  localparam int CORD_LAT = CORDIC_STEPS + 2;
  localparam int LAT      = 2 + qte_pkg::DIV_LAT + E_DLY + CORD_LAT + 1;
  localparam int EW       = qte_pkg::EW;
  localparam int OPW      = qte_pkg::OPW;
  localparam int NUMW     = qte_pkg::NUMW;

  // configuration
  logic [qte_pkg::AXIS_W-1:0] axis_order_r;
  logic [qte_pkg::THR_W-1:0]  thr_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_order_r <= '0;
      thr_r        <= qte_pkg::THR_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        qte_pkg::REG_AXIS_ORDER: axis_order_r <= cfg_pwdata[qte_pkg::AXIS_W-1:0];
        qte_pkg::REG_SING_THR:   thr_r        <= cfg_pwdata[qte_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      qte_pkg::REG_AXIS_ORDER: cfg_prdata = qte_pkg::CFG_DW'(axis_order_r);
      qte_pkg::REG_SING_THR:   cfg_prdata = qte_pkg::CFG_DW'(thr_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  qte_pkg::order_t ord;
  assign ord = qte_pkg::decode_order(axis_order_r);

  // pipeline control
  logic [LAT-1:0] vld_r;
  logic           en;

  assign out_tvalid = vld_r[LAT-1];
  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n)  vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  // stage 1: components to Q1.14
  logic signed [DATA_WIDTH-1:0] fx, fy, fz, fw;
  logic signed [qte_pkg::QW-1:0] qx_r, qy_r, qz_r, qw_r;

  assign fx = in_tdata[0*DATA_WIDTH +: DATA_WIDTH];
  assign fy = in_tdata[1*DATA_WIDTH +: DATA_WIDTH];
  assign fz = in_tdata[2*DATA_WIDTH +: DATA_WIDTH];
  assign fw = in_tdata[3*DATA_WIDTH +: DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r <= qte_pkg::QW'(fx >>> PRE);
      qy_r <= qte_pkg::QW'(fy >>> PRE);
      qz_r <= qte_pkg::QW'(fz >>> PRE);
      qw_r <= qte_pkg::QW'(fw >>> PRE);
    end
  end

  // stage 2: products
  logic signed [qte_pkg::PW-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= qx_r * qx_r;
      yy_r <= qy_r * qy_r;
      zz_r <= qz_r * qz_r;
      ww_r <= qw_r * qw_r;
      xy_r <= qx_r * qy_r;
      wz_r <= qw_r * qz_r;
      xz_r <= qx_r * qz_r;
      wy_r <= qw_r * qy_r;
      yz_r <= qy_r * qz_r;
      wx_r <= qw_r * qx_r;
    end
  end

  // numerators, norm and entry selection for the divider lanes
  logic [qte_pkg::NORMW-1:0] norm;
  logic signed [NUMW-1:0]    num_m  [4][4];
  logic signed [NUMW-1:0]    num_s  [qte_pkg::SLOTS];
  logic                      diag_s [qte_pkg::SLOTS];
  logic signed [EW-1:0]      ent    [qte_pkg::SLOTS];

  assign norm = qte_pkg::NORMW'($unsigned(xx_r)) + qte_pkg::NORMW'($unsigned(yy_r))
              + qte_pkg::NORMW'($unsigned(zz_r)) + qte_pkg::NORMW'($unsigned(ww_r));

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) num_m[r][c] = '0;
    end
    num_m[0][0] = NUMW'(ww_r) + NUMW'(xx_r) - NUMW'(yy_r) - NUMW'(zz_r);
    num_m[1][1] = NUMW'(ww_r) - NUMW'(xx_r) + NUMW'(yy_r) - NUMW'(zz_r);
    num_m[2][2] = NUMW'(ww_r) - NUMW'(xx_r) - NUMW'(yy_r) + NUMW'(zz_r);
    num_m[0][1] = (NUMW'(xy_r) - NUMW'(wz_r)) <<< 1;
    num_m[0][2] = (NUMW'(xz_r) + NUMW'(wy_r)) <<< 1;
    num_m[1][0] = (NUMW'(xy_r) + NUMW'(wz_r)) <<< 1;
    num_m[1][2] = (NUMW'(yz_r) - NUMW'(wx_r)) <<< 1;
    num_m[2][0] = (NUMW'(xz_r) - NUMW'(wy_r)) <<< 1;
    num_m[2][1] = (NUMW'(yz_r) + NUMW'(wx_r)) <<< 1;
  end

  // repeated: ij ik ii ji ki jk jj; otherwise: ii ji ki kj kk jk jj
  always_comb begin
    if (ord.rep) begin
      num_s[0] = num_m[ord.i][ord.j];
      num_s[1] = num_m[ord.i][ord.k];
      num_s[2] = num_m[ord.i][ord.i];
      num_s[3] = num_m[ord.j][ord.i];
      num_s[4] = num_m[ord.k][ord.i];
    end else begin
      num_s[0] = num_m[ord.i][ord.i];
      num_s[1] = num_m[ord.j][ord.i];
      num_s[2] = num_m[ord.k][ord.i];
      num_s[3] = num_m[ord.k][ord.j];
      num_s[4] = num_m[ord.k][ord.k];
    end
    num_s[5]  = num_m[ord.j][ord.k];
    num_s[6]  = num_m[ord.j][ord.j];
    diag_s[0] = !ord.rep;
    diag_s[1] = 1'b0;
    diag_s[2] = ord.rep;
    diag_s[3] = 1'b0;
    diag_s[4] = !ord.rep;
    diag_s[5] = 1'b0;
    diag_s[6] = 1'b1;
  end

  for (genvar s = 0; s < qte_pkg::SLOTS; s++) begin : g_lane
    qte_div u_div (
      .clk  (clk),
      .en   (en),
      .num  (num_s[s]),
      .norm (norm),
      .diag (diag_s[s]),
      .ent  (ent[s])
    );
  end

  // magnitude: squares then square root, entries delayed alongside
  logic signed [2*EW-1:0] sq0, sq1;
  logic [qte_pkg::SQW-1:0] sq0_r, sq1_r;
  logic [qte_pkg::MAGW-1:0] mag;
  logic signed [EW-1:0] ed_r [E_DLY][qte_pkg::SLOTS];

  assign sq0 = ent[0] * ent[0];
  assign sq1 = ent[1] * ent[1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq0_r <= $unsigned(sq0);
      sq1_r <= $unsigned(sq1);
      for (int s = 0; s < qte_pkg::SLOTS; s++) begin
        ed_r[0][s] <= ent[s];
        for (int d = 1; d < E_DLY; d++) ed_r[d][s] <= ed_r[d-1][s];
      end
    end
  end

  qte_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sq0_r + sq1_r),
    .root (mag)
  );

  // atan2 operands
  logic signed [OPW-1:0] e [qte_pkg::SLOTS];
  logic signed [OPW-1:0] mag_s;
  logic signed [OPW-1:0] y2, x2, y1n, x1n, y3n, x3n, y1s, x1s;
  logic                  sing;

  always_comb begin
    for (int s = 0; s < qte_pkg::SLOTS; s++) e[s] = OPW'(ed_r[E_DLY-1][s]);
    mag_s = OPW'(mag);
    if (ord.rep) begin
      y2  = mag_s;  x2  = e[2];
      y1n = e[0];   x1n = e[1];
      y3n = e[3];   x3n = -e[4];
    end else begin
      y2  = -e[2];  x2  = mag_s;
      y1n = e[3];   x1n = e[4];
      y3n = e[1];   x3n = e[0];
    end
    y1s = -e[5];
    x1s = e[6];
  end

  assign sing = mag <= qte_pkg::MAGW'({thr_r, 16'b0});

  logic signed [qte_pkg::AW-1:0] a1n, a2, a3n, a1s;

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a2  (.clk(clk), .en(en), .y_in(y2),  .x_in(x2),
                                                  .angle(a2));
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a1n (.clk(clk), .en(en), .y_in(y1n), .x_in(x1n),
                                                  .angle(a1n));
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a3n (.clk(clk), .en(en), .y_in(y3n), .x_in(x3n),
                                                  .angle(a3n));
  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a1s (.clk(clk), .en(en), .y_in(y1s), .x_in(x1s),
                                                  .angle(a1s));

  logic sing_r [CORD_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r[0] <= sing;
      for (int d = 1; d < CORD_LAT; d++) sing_r[d] <= sing_r[d-1];
    end
  end

  // select, parity and frame
  logic signed [qte_pkg::AW-1:0] b1, b2, b3, c1, c2, c3;
  logic [qte_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  always_comb begin
    b1 = sing_r[CORD_LAT-1] ? a1s : a1n;
    b2 = a2;
    b3 = sing_r[CORD_LAT-1] ? '0 : a3n;
    if (ord.par) begin
      b1 = -b1;
      b2 = -b2;
      b3 = -b3;
    end
    c2 = b2;
    c1 = ord.frame ? b3 : b1;
    c3 = ord.frame ? b1 : b3;
  end

  always_ff @(posedge clk) begin
    if (en) out_tdata_r <= qte_pkg::OUT_TDATA_W'({c3, c2, c1});
  end

  assign out_tdata = out_tdata_r;

endmodule

FILE: hdl/qte_div.sv
// Pipelined restoring divider: one matrix entry, num * 2^30 / norm rounded, one bit per stage.
// Depends on qte_pkg. Advances when en is high.
module qte_div (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [qte_pkg::NUMW-1:0]     num,
  input  logic        [qte_pkg::NORMW-1:0]    norm,
  input  logic                                diag,
  output logic signed [qte_pkg::EW-1:0]       ent
);

  localparam int DIVQ = qte_pkg::DIVQ;
  localparam int REMW = qte_pkg::REMW;

  logic [REMW-1:0]            rem_r  [DIVQ];
  logic [qte_pkg::NORMW-1:0]  den_r  [DIVQ];
  logic [DIVQ-1:0]            quo_r  [DIVQ+1];
  logic                       neg_r  [DIVQ+1];
  logic                       zero_r [DIVQ+1];
  logic                       diag_r [DIVQ+1];
  logic signed [qte_pkg::EW-1:0] ent_r;

  logic [qte_pkg::NORMW-1:0] mag_num;
  assign mag_num = num[qte_pkg::NUMW-1] ? qte_pkg::NORMW'(-num) : qte_pkg::NORMW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= (REMW'(mag_num) << qte_pkg::MFRAC) + REMW'(norm >> 1);
      den_r[0]  <= norm;
      quo_r[0]  <= '0;
      neg_r[0]  <= num[qte_pkg::NUMW-1];
      zero_r[0] <= (norm == '0);
      diag_r[0] <= diag;
    end
  end

  for (genvar t = 0; t < DIVQ; t++) begin : g_step
    localparam int B = DIVQ - 1 - t;
    logic [REMW-1:0] sub;
    logic            take;
    assign sub  = REMW'(den_r[t]) << B;
    assign take = rem_r[t] >= sub;

    if (t < DIVQ - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[t+1] <= take ? rem_r[t] - sub : rem_r[t];
          den_r[t+1] <= den_r[t];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[t+1]  <= take ? (quo_r[t] | (DIVQ'(1) << B)) : quo_r[t];
        neg_r[t+1]  <= neg_r[t];
        zero_r[t+1] <= zero_r[t];
        diag_r[t+1] <= diag_r[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[DIVQ]) begin
        ent_r <= diag_r[DIVQ] ? (qte_pkg::EW'(1) << qte_pkg::MFRAC) : '0;
      end else if (neg_r[DIVQ]) begin
        ent_r <= -qte_pkg::EW'(quo_r[DIVQ]);
      end else begin
        ent_r <= qte_pkg::EW'(quo_r[DIVQ]);
      end
    end
  end

  assign ent = ent_r;

endmodule

FILE: hdl/qte_isqrt.sv
// Pipelined floor integer square root, two radicand bits per stage.
// Depends on qte_pkg. Advances when en is high.
module qte_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [qte_pkg::SQW-1:0]       rad,
  output logic [qte_pkg::MAGW-1:0]      root
);

  localparam int N   = qte_pkg::SQ_STEPS;
  localparam int SQW = qte_pkg::SQW;

  logic [SQW-1:0] v_r   [N];
  logic [SQW-1:0] res_r [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]   <= rad;
      res_r[0] <= '0;
    end
  end

  for (genvar t = 0; t < N; t++) begin : g_step
    logic [SQW-1:0] bitv, trial;
    logic           take;
    assign bitv  = SQW'(1) << (SQW - 2 - 2 * t);
    assign trial = res_r[t] + bitv;
    assign take  = v_r[t] >= trial;

    if (t < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) v_r[t+1] <= take ? v_r[t] - trial : v_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) res_r[t+1] <= take ? (res_r[t] >> 1) + bitv : (res_r[t] >> 1);
    end
  end

  assign root = res_r[N][qte_pkg::MAGW-1:0];

endmodule

FILE: hdl/qte_cordic.sv
// Pipelined CORDIC atan2(y, x) in vectoring mode, one rotation per stage,
// rounded and saturated to Q2.12. Depends on qte_pkg.
module qte_cordic #(
  parameter int STEPS = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [qte_pkg::OPW-1:0]    y_in,
  input  logic signed [qte_pkg::OPW-1:0]    x_in,
  output logic signed [qte_pkg::AW-1:0]     angle
);

  localparam int CW = qte_pkg::CW;
  localparam int ZW = qte_pkg::ZW;
  localparam logic signed [ZW:0] PI_LIM = (ZW+1)'(qte_pkg::PI_Q12);

  logic signed [CW-1:0] x_r   [STEPS];
  logic signed [CW-1:0] y_r   [STEPS];
  logic signed [ZW-1:0] z_r   [STEPS+1];
  logic                 nil_r [STEPS+1];
  logic signed [qte_pkg::AW-1:0] angle_r;

  logic signed [CW-1:0] xe, ye;
  assign xe = CW'(x_in);
  assign ye = CW'(y_in);

  always_ff @(posedge clk) begin
    if (en) begin
      nil_r[0] <= (x_in == '0) && (y_in == '0);
      if (!x_in[qte_pkg::OPW-1]) begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        z_r[0] <= '0;
      end else if (!y_in[qte_pkg::OPW-1]) begin
        x_r[0] <= ye;
        y_r[0] <= -xe;
        z_r[0] <= qte_pkg::HALF_PI_Q28;
      end else begin
        x_r[0] <= -ye;
        y_r[0] <= xe;
        z_r[0] <= -qte_pkg::HALF_PI_Q28;
      end
    end
  end

  for (genvar t = 0; t < STEPS; t++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = qte_pkg::atan_q28(t);
    logic signed [CW-1:0] xs, ys;
    logic                 up;
    assign xs = x_r[t] >>> t;
    assign ys = y_r[t] >>> t;
    assign up = !y_r[t][CW-1];

    if (t < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[t+1] <= up ? x_r[t] + ys : x_r[t] - ys;
          y_r[t+1] <= up ? y_r[t] - xs : y_r[t] + xs;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        z_r[t+1]   <= up ? z_r[t] + ATAN : z_r[t] - ATAN;
        nil_r[t+1] <= nil_r[t];
      end
    end
  end

  logic signed [ZW:0] zsum, zq;
  assign zsum = (ZW+1)'(z_r[STEPS]) + (ZW+1)'(32768);
  assign zq   = zsum >>> 16;

  always_ff @(posedge clk) begin
    if (en) begin
      if (nil_r[STEPS])        angle_r <= '0;
      else if (zq > PI_LIM)    angle_r <= qte_pkg::PI_Q12;
      else if (zq < -PI_LIM)   angle_r <= -qte_pkg::PI_Q12;
      else                     angle_r <= qte_pkg::AW'(zq);
    end
  end

  assign angle = angle_r;

endmodule

FILE: hdl/qte_checker.sv
// Port-level checks for quaternion_to_euler_angles_core, bound to the top level.
// Depends on qte_pkg.
module qte_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [qte_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            cfg_pready
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("request refused while output drains");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      $signed(out_tdata[14:0])  <= 15'sd12868 && $signed(out_tdata[14:0])  >= -15'sd12868 &&
      $signed(out_tdata[29:15]) <= 15'sd12868 && $signed(out_tdata[29:15]) >= -15'sd12868 &&
      $signed(out_tdata[44:30]) <= 15'sd12868 && $signed(out_tdata[44:30]) >= -15'sd12868)
    else $error("angle beyond pi");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("config port not ready");

endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
